// File: hdl/mwe_pkg.sv
// Shared types and constants for the Microwire EEPROM read master.
package mwe_pkg;

  // Field widths of the stream items and width of the delay counter
  localparam int unsigned AddrFieldW = 10;
  localparam int unsigned WordFieldW = 16;
  localparam int unsigned UnitW      = 16;
  localparam int unsigned DelayW     = 18;

  // Default geometry of the EEPROM
  localparam int unsigned AddressBitsDef = 10;
  localparam int unsigned DataBitsDef    = 16;

  // Reset value of the unit length register
  localparam logic [UnitW-1:0] UnitTicksReset = 16'd500;

  // Sequencer phases
  typedef enum logic [3:0] {
    PhIdle   = 4'd0,
    PhCsWait = 4'd1,
    PhSetup  = 4'd2,
    PhHigh   = 4'd3,
    PhLow    = 4'd4,
    PhCmdGap = 4'd5,
    PhAdrGap = 4'd6,
    PhRdHigh = 4'd7,
    PhRdLow  = 4'd8,
    PhTail   = 4'd9
  } phase_e;

  // Result of one tick
  typedef struct packed {
    logic [WordFieldW-1:0] read_word;
    logic                  done_res;
    logic                  busy_res;
    logic                  data_in_pin;
    logic                  serial_clock;
    logic                  chip_select;
  } res_t;

endpackage

// File: hdl/mwe_seq.sv
// Tick sequencer: phase, delay and bit state plus the pin levels of each tick.
module mwe_seq #(
  parameter int unsigned ADDRESS_BITS = mwe_pkg::AddressBitsDef,
  parameter int unsigned DATA_BITS    = mwe_pkg::DataBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic                            action_i,
  input  logic [mwe_pkg::AddrFieldW-1:0]  word_address_i,
  input  logic                            data_out_pin_i,
  input  logic [mwe_pkg::UnitW-1:0]       unit_ticks_i,
  output mwe_pkg::res_t                   res_o
);

  localparam int unsigned CntMax  = (ADDRESS_BITS + 3 > DATA_BITS) ? ADDRESS_BITS + 3 : DATA_BITS;
  localparam int unsigned CntW    = $clog2(CntMax);
  localparam int unsigned AdrIdxW = $clog2(ADDRESS_BITS);
  localparam logic [CntW-1:0] CmdLast  = CntW'(2);
  localparam logic [CntW-1:0] CmdBits  = CntW'(3);
  localparam logic [CntW-1:0] SendLast = CntW'(ADDRESS_BITS + 2);
  localparam logic [CntW-1:0] DataLast = CntW'(DATA_BITS - 1);

  mwe_pkg::phase_e                 phase_q, phase_d;
  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic [mwe_pkg::DelayW-1:0]      dly_q, dly_d;
  logic [ADDRESS_BITS-1:0]         adr_q, adr_d;
  logic [DATA_BITS-1:0]            shw_q, shw_d;

  logic [mwe_pkg::DelayW-1:0]      unit1, unit2, unit3, dly_dec;
  logic [CntW-1:0]                 adr_pos;
  logic                            done, send_bit;
  logic [mwe_pkg::WordFieldW-1:0]  word;

  // Delay lengths of one, two and three units; a zero unit counts as one
  assign unit1 = (unit_ticks_i == '0) ? mwe_pkg::DelayW'(1)
                                      : mwe_pkg::DelayW'(unit_ticks_i);
  assign unit2 = {unit1[mwe_pkg::DelayW-2:0], 1'b0};
  assign unit3 = unit1 + unit2;
  assign dly_dec = (dly_q != '0) ? dly_q - 1'b1 : dly_q;

  // Advance the phase sequence by one tick
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    dly_d   = dly_q;
    adr_d   = adr_q;
    shw_d   = shw_q;
    done    = 1'b0;
    word    = '0;
    if (phase_q == mwe_pkg::PhIdle) begin
      if (action_i) begin
        adr_d   = ADDRESS_BITS'(word_address_i);
        shw_d   = '0;
        cnt_d   = '0;
        phase_d = mwe_pkg::PhCsWait;
        dly_d   = unit2;
      end
    end else begin
      dly_d = dly_dec;
      if (dly_dec == '0) begin
        unique case (phase_q)
          mwe_pkg::PhCsWait: begin
            cnt_d   = '0;
            phase_d = mwe_pkg::PhSetup;
            dly_d   = unit1;
          end
          mwe_pkg::PhSetup: begin
            phase_d = mwe_pkg::PhHigh;
            dly_d   = unit2;
          end
          mwe_pkg::PhHigh: begin
            phase_d = mwe_pkg::PhLow;
            dly_d   = unit1;
          end
          mwe_pkg::PhLow: begin
            if (cnt_q == CmdLast) begin
              phase_d = mwe_pkg::PhCmdGap;
              dly_d   = unit3;
            end else if (cnt_q >= SendLast) begin
              phase_d = mwe_pkg::PhAdrGap;
              dly_d   = unit3;
            end else begin
              cnt_d   = cnt_q + 1'b1;
              phase_d = mwe_pkg::PhSetup;
              dly_d   = unit1;
            end
          end
          mwe_pkg::PhCmdGap: begin
            cnt_d   = CmdBits;
            phase_d = mwe_pkg::PhSetup;
            dly_d   = unit1;
          end
          mwe_pkg::PhAdrGap: begin
            cnt_d   = '0;
            phase_d = mwe_pkg::PhRdHigh;
            dly_d   = unit2;
          end
          mwe_pkg::PhRdHigh: begin
            // sample on the tick that drops the clock, first bit ends as MSB
            shw_d   = {shw_q[DATA_BITS-2:0], data_out_pin_i};
            phase_d = mwe_pkg::PhRdLow;
            dly_d   = unit2;
          end
          mwe_pkg::PhRdLow: begin
            if (cnt_q >= DataLast) begin
              phase_d = mwe_pkg::PhTail;
              dly_d   = unit2;
            end else begin
              cnt_d   = cnt_q + 1'b1;
              phase_d = mwe_pkg::PhRdHigh;
              dly_d   = unit2;
            end
          end
          mwe_pkg::PhTail: begin
            phase_d = mwe_pkg::PhIdle;
            cnt_d   = '0;
            done    = 1'b1;
            word    = mwe_pkg::WordFieldW'(shw_q);
          end
          default: begin
            phase_d = mwe_pkg::PhIdle;
          end
        endcase
      end
    end
  end

  // Select the bit to send: command 1,1,0, then the address MSB first
  assign adr_pos = SendLast - cnt_d;
  always_comb begin
    if (cnt_d < CmdBits) begin
      send_bit = (cnt_d < CmdLast);
    end else if (cnt_d <= SendLast) begin
      send_bit = adr_d[adr_pos[AdrIdxW-1:0]];
    end else begin
      send_bit = 1'b0;
    end
  end

  // Pin levels held during this tick
  always_comb begin
    res_o.chip_select  = (phase_d != mwe_pkg::PhIdle);
    res_o.busy_res     = (phase_d != mwe_pkg::PhIdle);
    res_o.serial_clock = (phase_d == mwe_pkg::PhHigh) || (phase_d == mwe_pkg::PhRdHigh);
    res_o.data_in_pin  = ((phase_d == mwe_pkg::PhSetup) || (phase_d == mwe_pkg::PhHigh) ||
                          (phase_d == mwe_pkg::PhLow)) && send_bit;
    res_o.done_res     = done;
    res_o.read_word    = word;
  end

  // Hold the state between ticks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mwe_pkg::PhIdle;
      cnt_q   <= '0;
      dly_q   <= '0;
      adr_q   <= '0;
      shw_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      dly_q   <= dly_d;
      adr_q   <= adr_d;
      shw_q   <= shw_d;
    end
  end

endmodule

// File: hdl/microwire_eeprom_read_master_core.sv
// Top level of the Microwire EEPROM read master: stream ports, unit register, result register.
//
// Each input item is one timing tick and produces exactly one result item with the pin
// levels of that tick. A read request in idle starts the full chip select, command,
// address and 16-bit read sequence; requests are ignored while a read is running. Delays
// are counted in ticks as multiples of the unit_ticks register (0 counts as 1). One item
// is accepted per clock cycle and its result appears in the result register on the next
// cycle; the sequencer state is updated in that single cycle, and input stalls only when
// the result register is full and not being taken.
module microwire_eeprom_read_master_core #(
  parameter int unsigned ADDRESS_BITS = mwe_pkg::AddressBitsDef,
  parameter int unsigned DATA_BITS    = mwe_pkg::DataBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // unit_ticks write channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [mwe_pkg::UnitW-1:0]  cfg_data_i,
  // tick input
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [15:0]                s_axis_tdata_i,   // word_address[9:0], data_out_pin[10]
  input  logic                       s_axis_tuser_i,   // action[0]
  // tick result
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [23:0]                m_axis_tdata_o    // chip_select[0], serial_clock[1],
                                                       // data_in_pin[2], busy_res[3],
                                                       // done_res[4], read_word[20:5]
);

  logic [mwe_pkg::UnitW-1:0] unit_q;
  logic                      out_valid_q;
  logic [23:0]               out_data_q;
  logic                      step;
  mwe_pkg::res_t             res;

  // Accept a tick whenever the result register is free or draining
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign step            = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // Hold the unit length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= mwe_pkg::UnitTicksReset;
    end else if (cfg_valid_i) begin
      unit_q <= cfg_data_i;
    end
  end

  mwe_seq #(
    .ADDRESS_BITS(ADDRESS_BITS),
    .DATA_BITS   (DATA_BITS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .action_i      (s_axis_tuser_i),
    .word_address_i(s_axis_tdata_i[9:0]),
    .data_out_pin_i(s_axis_tdata_i[10]),
    .unit_ticks_i  (unit_q),
    .res_o         (res)
  );

  // Result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result item
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= {3'b000, res.read_word, res.done_res, res.busy_res,
                     res.data_in_pin, res.serial_clock, res.chip_select};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
